// File: src/smc_pkg.sv
package smc_pkg;

   localparam int KIND_W             = 2;
   localparam int INDEX_W            = 4;
   localparam int ADDR_W             = 32;
   localparam int MAP_W              = 16;
   localparam int COUNT_W            = 5;
   localparam int VALUE_W            = 32;
   localparam int REQ_DATA_W         = 72;
   localparam int RSP_DATA_W         = 56;
   localparam int ENTRIES_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD     = 2'd0,
      KIND_CLASSIFY = 2'd1,
      KIND_READ     = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec_load;
      logic scan_step;
      logic out_load;
   } smc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     scan_last;
   } smc_status_type;

endpackage

// File: src/subnet_match_counter_top.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: kind; tdata: index, address, netmask
// rsp      out        rsp_tvalid/rsp_tready  tdata: match map, match count, counter value
//
// One item is in work at a time. A load, a counter read or an unused kind passes
// through the execute and finish states before its result shows; a classify also
// passes through the scan and drain states, the single comparator visiting one table
// entry per cycle through the registered table read. Reset clears the valid bits and
// the control state; the tables need no clearing pass. A waiting result holds in the
// output register, and the next item is taken in the cycle that result leaves.
module subnet_match_counter_top
   import smc_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] entry_index, [35:4] address, [67:36] netmask, [71:68] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] match_map, [20:16] match_count, [52:21] counter_value, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   smc_cmd_type    cmd;
   smc_status_type status;

   smc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smc_datapath #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

   a_ready_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("input taken while the result slot stays occupied");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("finished item did not show a result");

   a_load_not_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec_load && cmd.scan_step))
      else $error("table load during a scan");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && status.scan_last) |=> !cmd.scan_step)
      else $error("scan ran past the last entry");

endmodule

// File: src/smc_ctrl.sv
module smc_ctrl
   import smc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  smc_status_type status,
   output smc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_beat;

   // The block is idle and the result slot is free, or is emptied at this edge.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.capture   = req_beat;
      cmd.exec_load = (state_ff == ST_EXEC) && (status.kind == KIND_LOAD);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.out_load  = (state_ff == ST_FINISH);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.kind == KIND_CLASSIFY) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/smc_datapath.sv
module smc_datapath
   import smc_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  smc_cmd_type           cmd,
   output smc_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDXW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EXTW  = IDXW + INDEX_W;
   localparam int PAD_W = RSP_DATA_W - VALUE_W - COUNT_W - MAP_W;

   // Entry table: prefix in the upper half, mask in the lower half.
   logic [2*ADDR_W-1:0]   entry_mem [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];

   kind_type              kind_ff;
   logic [INDEX_W-1:0]    idx_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [ADDR_W-1:0]     mask_ff;
   logic [ENTRIES-1:0]    valid_ff;
   logic [IDXW-1:0]       scan_idx_ff;
   logic                  cmp_vld_ff;
   logic [IDXW-1:0]       cmp_idx_ff;
   logic [2*ADDR_W-1:0]   entry_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [MAP_W-1:0]      map_ff, map_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [MAP_W-1:0]      out_map_ff;
   logic [COUNT_W-1:0]    out_count_ff;
   logic [VALUE_W-1:0]    out_value_ff;

   logic [EXTW-1:0]          idx_ext;
   logic [IDXW-1:0]          mem_idx;
   logic                     idx_in_range;
   logic [IDXW-1:0]          rd_addr;
   logic [EXTW-1:0]          cmp_ext;
   logic                     hit;
   logic [COUNT_BITS-1:0]    cnt_inc;
   logic [COUNT_BITS+VALUE_W-1:0] cnt_ext;
   logic [VALUE_W-1:0]       read_value;

   assign idx_ext      = EXTW'(idx_ff);
   assign mem_idx      = idx_ext[IDXW-1:0];
   assign idx_in_range = idx_ext < EXTW'(ENTRIES);
   assign rd_addr      = cmd.scan_step ? scan_idx_ff : mem_idx;
   assign cmp_ext      = EXTW'(cmp_idx_ff);

   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                ((addr_ff & entry_rd_ff[ADDR_W-1:0]) == entry_rd_ff[2*ADDR_W-1:ADDR_W]);

   assign cnt_inc = (cnt_rd_ff == {COUNT_BITS{1'b1}}) ? cnt_rd_ff
                                                        : cnt_rd_ff + COUNT_BITS'(1);

   // Counters narrower than the result field are zero extended.
   assign cnt_ext    = (COUNT_BITS + VALUE_W)'(cnt_rd_ff);
   assign read_value = (idx_in_range && valid_ff[mem_idx]) ? cnt_ext[VALUE_W-1:0]
                                                           : '0;

   assign status.kind      = kind_ff;
   assign status.scan_last = (scan_idx_ff == IDXW'(ENTRIES - 1));

   assign rsp_tdata = {PAD_W'(0), out_value_ff, out_count_ff, out_map_ff};

   always_comb begin
      map_in   = map_ff;
      count_in = count_ff;
      if (hit) begin
         if (cmp_ext < EXTW'(MAP_W)) begin
            map_in[cmp_ext[INDEX_W-1:0]] = 1'b1;
         end
         if (count_ff != {COUNT_W{1'b1}}) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_tuser);
         idx_ff  <= req_tdata[INDEX_W-1:0];
         addr_ff <= req_tdata[INDEX_W+ADDR_W-1:INDEX_W];
         mask_ff <= req_tdata[INDEX_W+2*ADDR_W-1:INDEX_W+ADDR_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_step;
         if (cmd.capture) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_step && !status.scan_last) begin
            scan_idx_ff <= scan_idx_ff + IDXW'(1);
         end
         if (cmd.exec_load && idx_in_range) begin
            valid_ff[mem_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_idx_ff;
      if (cmd.capture) begin
         map_ff   <= '0;
         count_ff <= '0;
      end else begin
         map_ff   <= map_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_load && idx_in_range) begin
         entry_mem[mem_idx] <= {addr_ff, mask_ff};
      end
      entry_rd_ff <= entry_mem[rd_addr];
   end

   // A load clears the counter; a hit bumps the entry compared in this cycle.
   always_ff @(posedge clock) begin
      if (cmd.exec_load && idx_in_range) begin
         cnt_mem[mem_idx] <= '0;
      end else if (hit) begin
         cnt_mem[cmp_idx_ff] <= cnt_inc;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (kind_ff)
            KIND_CLASSIFY: begin
               out_map_ff   <= map_ff;
               out_count_ff <= count_ff;
               out_value_ff <= '0;
            end
            KIND_READ: begin
               out_map_ff   <= '0;
               out_count_ff <= '0;
               out_value_ff <= read_value;
            end
            default: begin
               out_map_ff   <= '0;
               out_count_ff <= '0;
               out_value_ff <= '0;
            end
         endcase
      end
   end

endmodule

// File: dv/tb_subnet_match_counter_top.sv
module tb_subnet_match_counter_top
   import smc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = ENTRIES_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [3:0] entry_index, [35:4] address, [67:36] netmask, [71:68] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] kind
   logic [KIND_W-1:0]     req_tuser = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] match_map, [20:16] match_count, [52:21] counter_value, [55:53] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // The sender stops idling over one stretch of the random items.
   bit sender_steady = 1'b0;
   int idle_cycles = 0;

   typedef struct packed {
      bit [MAP_W-1:0]   map;
      bit [COUNT_W-1:0] count;
      bit [VALUE_W-1:0] value;
   } subnet_result_type;

   class match_scoreboard;
      bit [ADDR_W-1:0]   prefix_tab [ENTRIES];
      bit [ADDR_W-1:0]   mask_tab [ENTRIES];
      bit                valid_tab [ENTRIES];
      bit [VALUE_W-1:0]  hits [ENTRIES];
      subnet_result_type pending [$];
      int                errors;
      int                checked;

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      // Updates the table copy and queues the result the block owes for this beat.
      function void note_request(kind_type kind, bit [INDEX_W-1:0] idx,
                                 bit [ADDR_W-1:0] addr, bit [ADDR_W-1:0] mask);
         subnet_result_type r;
         int n;
         r = '0;
         n = 0;
         case (kind)
            KIND_LOAD: begin
               prefix_tab[idx] = addr;
               mask_tab[idx]   = mask;
               valid_tab[idx]  = 1'b1;
               hits[idx]       = '0;
            end
            KIND_CLASSIFY: begin
               for (int e = 0; e < ENTRIES; e++) begin
                  if (valid_tab[e] && (addr & mask_tab[e]) == prefix_tab[e]) begin
                     if (hits[e] != '1) begin
                        hits[e]++;
                     end
                     r.map[e] = 1'b1;
                     n++;
                  end
               end
               r.count = (n > 31) ? 5'd31 : COUNT_W'(n);
            end
            KIND_READ: begin
               r.value = hits[idx];
            end
            default: begin
            end
         endcase
         pending.push_back(r);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         subnet_result_type want;
         checked++;
         if (pending.size() == 0) begin
            flag($sformatf("result beat with nothing pending, tdata=%h", data));
            return;
         end
         want = pending.pop_front();
         if (data[15:0] !== want.map || data[20:16] !== want.count ||
             data[52:21] !== want.value) begin
            flag($sformatf({"result %0d: map exp %h got %h, count exp %0d got %0d, ",
                            "value exp %h got %h"},
                           checked, want.map, data[15:0], want.count, data[20:16],
                           want.value, data[52:21]));
         end
      endfunction
   endclass

   match_scoreboard sb = new();

   subnet_match_counter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_item(kind_type kind, bit [INDEX_W-1:0] idx,
                            bit [ADDR_W-1:0] addr, bit [ADDR_W-1:0] mask);
      @(negedge clock);
      if (!sender_steady) begin
         while ($urandom_range(99) < 21) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, mask, addr, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, idx, addr, mask);
   endtask

   // Receiver: random stalls, one long hold-off to back the block up, one steady stretch.
   initial begin
      bit held_off;
      held_off = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held_off && sb.checked >= 120) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (250) @(negedge clock);
         end else if (sb.checked >= 250 && sb.checked < 350) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int       sel;
      int       e;
      kind_type kind;
      bit [ADDR_W-1:0] addr;
      bit [ADDR_W-1:0] mask;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table first, then a host route, then all other entries matching everything.
      send_item(KIND_READ, 4'd0, 32'h0, 32'h0);
      send_item(KIND_CLASSIFY, 4'd0, 32'hFFFF_FFFF, 32'h0);
      send_item(KIND_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_LOAD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_CLASSIFY, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_CLASSIFY, 4'd15, 32'hFFFF_FFFE, 32'h0);
      for (int i = 0; i < ENTRIES - 1; i++) begin
         send_item(KIND_LOAD, INDEX_W'(i), 32'h0, 32'h0);
      end
      send_item(KIND_CLASSIFY, 4'd7, 32'h1234_5678, 32'hFFFF_FFFF);
      send_item(KIND_CLASSIFY, 4'd0, 32'hFFFF_FFFF, 32'h0);
      send_item(KIND_READ, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_READ, 4'd0, 32'h0, 32'h0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel  = $urandom_range(99);
         e    = $urandom_range(ENTRIES - 1);
         addr = $urandom;
         mask = $urandom;
         if (sel < 25) begin
            kind = KIND_LOAD;
            // Mostly proper subnets; the rest keep host bits or a scattered mask.
            if ($urandom_range(4) != 0) begin
               mask = ~(32'hFFFF_FFFF >> $urandom_range(32));
               addr = addr & mask;
            end
         end else if (sel < 70) begin
            kind = KIND_CLASSIFY;
            if ($urandom_range(3) != 0) begin
               addr = sb.prefix_tab[e] | (addr & ~sb.mask_tab[e]);
            end
         end else if (sel < 95) begin
            kind = KIND_READ;
         end else begin
            kind = KIND_UNUSED;
         end
         sender_steady = (i >= 150 && i < 250);
         send_item(kind, INDEX_W'($urandom_range(ENTRIES - 1)), addr, mask);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (ENTRIES + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
src/smc_pkg.sv
src/smc_ctrl.sv
src/smc_datapath.sv
src/subnet_match_counter_top.sv
dv/tb_subnet_match_counter_top.sv
